### rtl/core/assert_macros.svh
//==============================================================================
// Assertion macros
// Shorthand for clocked concurrent assertions; expects clk and rst_n in scope.
//==============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hrrn_pkg.sv
//==============================================================================
// HRRN scheduler package
// Sizes, command and status codes and shared types of the ready-queue scheduler.
//==============================================================================
package hrrn_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int PID_W    = 16;
    localparam int DATA_W   = 32;
    localparam int ALPHA_W  = 9;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_HRRN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q8    = 1'd1;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [DATA_W-1:0] burst;
        logic [DATA_W-1:0] estimate;
        logic [DATA_W-1:0] arrival;
    } entry_t;

    typedef struct packed {
        logic [DATA_W-1:0] op_a;
        logic [DATA_W-1:0] op_b;
    } mul_req_t;

endpackage

### rtl/core/hrrn_if.sv
//==============================================================================
// HRRN scheduler channels
// Valid/ready channels for commands into and results out of the scheduler.
//==============================================================================
interface hrrn_cmd_if;
    import hrrn_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PID_W-1:0]    pid;
    logic [DATA_W-1:0]   last_burst;
    logic [DATA_W-1:0]   previous_estimate;

    modport source (output valid, command, pid, last_burst, previous_estimate,
                    input ready);
    modport sink   (input valid, command, pid, last_burst, previous_estimate,
                    output ready);
endinterface

interface hrrn_res_if;
    import hrrn_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    chosen_pid;
    logic [DATA_W-1:0]   new_estimate;

    modport source (output valid, status, chosen_pid, new_estimate, input ready);
    modport sink   (input valid, status, chosen_pid, new_estimate, output ready);
endinterface

### rtl/core/hrrn_mul.sv
//==============================================================================
// HRRN shared multiplier
// 32x32 unsigned multiplier with a registered product, shared by all steps.
//==============================================================================
module hrrn_mul (
    input  logic                       clk,
    input  hrrn_pkg::mul_req_t         req,
    output logic [hrrn_pkg::PROD_W-1:0] product
);
    import hrrn_pkg::*;

    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;

    assign product_next = PROD_W'(req.op_a) * PROD_W'(req.op_b);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;
endmodule

### rtl/core/hrrn_ready_queue_scheduler.sv
//==============================================================================
// HRRN ready-queue scheduler
// Ready table of processes with FIFO or highest-response-ratio-next dispatch.
//==============================================================================
//  channel   dir  handshake          payload
//  cmd_ch    in   valid/ready        command, pid, last_burst, previous_estimate
//  res_ch    out  valid/ready        status, chosen_pid, new_estimate
//  cfg       in   cfg_we (no wait)   cfg_index, cfg_data
//
//  Tick, enqueue and empty dispatch go straight to the post step.
//  FIFO dispatch reads slot 0 only; HRRN dispatch scans all n entries through the
//  shared multiplier (two products for the first entry, four for each other); both
//  then close the gap with a read/write compaction pass over the later slots.
//  Reset clears the fill count, tick time, state, settings and output valid; no clearing pass.
//  A waiting result stalls only the post step of the next command.
`include "assert_macros.svh"

module hrrn_ready_queue_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hrrn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hrrn_pkg::CFG_DATA_W-1:0] cfg_data,
    hrrn_cmd_if.sink                        cmd_ch,
    hrrn_res_if.source                      res_ch
);
    import hrrn_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOAD  = 10'b00_0000_0010,
        S_MUL_A = 10'b00_0000_0100,
        S_MUL_B = 10'b00_0000_1000,
        S_MUL_W = 10'b00_0001_0000,
        S_MUL_E = 10'b00_0010_0000,
        S_CMP   = 10'b00_0100_0000,
        S_SH_RD = 10'b00_1000_0000,
        S_SH_WR = 10'b01_0000_0000,
        S_POST  = 10'b10_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic                  policy_reg, policy_next;
    logic [ALPHA_W-1:0]    alpha_reg, alpha_next;
    logic [DATA_W-1:0]     tick_reg, tick_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      shift_reg, shift_next;

    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [PID_W-1:0]      best_pid_reg, best_pid_next;
    logic [DATA_W-1:0]     best_w_reg, best_w_next;
    logic [DATA_W-1:0]     best_e_reg, best_e_next;
    logic [DATA_W-1:0]     cur_w_reg, cur_w_next;
    logic [DATA_W-1:0]     cur_e_reg, cur_e_next;
    logic [PID_W-1:0]      cur_pid_reg, cur_pid_next;
    logic [ALPHA_W+DATA_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0]     p1_reg, p1_next;

    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PID_W-1:0]      res_pid_reg, res_pid_next;
    logic [DATA_W-1:0]     res_est_reg, res_est_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [PID_W-1:0]      out_pid_reg, out_pid_next;
    logic [DATA_W-1:0]     out_est_reg, out_est_next;

    entry_t                mem [QUEUE_DEPTH];
    entry_t                rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;

    mul_req_t              mul_req;
    logic [PROD_W-1:0]     product;

    logic                  accept;
    logic                  out_free;
    logic                  enq_room;
    logic [ALPHA_W-1:0]    alpha_sat;
    logic [DATA_W-1:0]     wait_now;
    logic [ALPHA_W+DATA_W-1:0] avg_sum;
    logic [DATA_W-1:0]     avg_est;

    hrrn_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign out_free     = !out_valid_reg || res_ch.ready;
    assign enq_room     = accept && (cmd_ch.command == CMD_ENQUEUE)
                       && (count_reg < CNT_W'(QUEUE_DEPTH));

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.status       = out_status_reg;
    assign res_ch.chosen_pid   = out_pid_reg;
    assign res_ch.new_estimate = out_est_reg;

    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign wait_now  = tick_reg - rd_data_reg.arrival;
    assign avg_sum   = acc_reg + product[ALPHA_W+DATA_W-1:0];
    assign avg_est   = (avg_sum[ALPHA_W+DATA_W-2:ALPHA_W-1] == '0) ? DATA_W'(1)
                     : avg_sum[ALPHA_W+DATA_W-2:ALPHA_W-1];

    // table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        mul_req = '0;
        case (state_reg)
            S_MUL_A:
            begin
                mul_req.op_a = DATA_W'(alpha_sat);
                mul_req.op_b = rd_data_reg.burst;
            end
            S_MUL_B:
            begin
                mul_req.op_a = DATA_W'(ALPHA_ONE - alpha_sat);
                mul_req.op_b = rd_data_reg.estimate;
            end
            S_MUL_W:
            begin
                mul_req.op_a = wait_now;
                mul_req.op_b = best_e_reg;
            end
            S_MUL_E:
            begin
                mul_req.op_a = best_w_reg;
                mul_req.op_b = cur_e_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    always_comb
    begin
        logic            scan_done;
        logic [IDX_W-1:0] sel_idx;

        state_next      = state_reg;
        policy_next     = policy_reg;
        alpha_next      = alpha_reg;
        tick_next       = tick_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        shift_next      = shift_reg;
        best_idx_next   = best_idx_reg;
        best_pid_next   = best_pid_reg;
        best_w_next     = best_w_reg;
        best_e_next     = best_e_reg;
        cur_w_next      = cur_w_reg;
        cur_e_next      = cur_e_reg;
        cur_pid_next    = cur_pid_reg;
        acc_next        = acc_reg;
        p1_next         = p1_reg;
        res_status_next = res_status_reg;
        res_pid_next    = res_pid_reg;
        res_est_next    = res_est_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pid_next    = out_pid_reg;
        out_est_next    = out_est_reg;

        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = rd_data_reg;

        scan_done = 1'b0;
        sel_idx   = best_idx_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY_MODE: policy_next = cfg_data[0];
                CFG_ALPHA_Q8:    alpha_next  = cfg_data;
                default:         policy_next = policy_reg;
            endcase
        end

        if (out_valid_reg && res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_pid_next    = '0;
                    res_est_next    = '0;
                    state_next      = S_POST;
                    case (cmd_ch.command)
                        CMD_TICK:
                        begin
                            tick_next = tick_reg + DATA_W'(1);
                        end
                        CMD_ENQUEUE:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_data.pid      = cmd_ch.pid;
                                wr_data.burst    = cmd_ch.last_burst;
                                wr_data.estimate = cmd_ch.previous_estimate;
                                wr_data.arrival  = tick_reg;
                                count_next       = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_LOAD;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_MUL_A;
            end
            S_MUL_A:
            begin
                cur_pid_next = rd_data_reg.pid;
                if (policy_reg == POLICY_FIFO)
                begin
                    best_idx_next = '0;
                    best_pid_next = rd_data_reg.pid;
                    best_e_next   = '0;
                    sel_idx       = '0;
                    scan_done     = 1'b1;
                end
                else
                begin
                    state_next = S_MUL_B;
                end
            end
            S_MUL_B:
            begin
                acc_next   = product[ALPHA_W+DATA_W-1:0];
                state_next = S_MUL_W;
            end
            S_MUL_W:
            begin
                cur_w_next = wait_now;
                cur_e_next = avg_est;
                if (idx_reg == '0)
                begin
                    best_idx_next = '0;
                    best_pid_next = cur_pid_reg;
                    best_w_next   = wait_now;
                    best_e_next   = avg_est;
                    sel_idx       = '0;
                    if (CNT_W'(idx_reg) + CNT_W'(1) < count_reg)
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        scan_done = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_MUL_E;
                end
            end
            S_MUL_E:
            begin
                p1_next    = product;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (p1_reg > product)
                begin
                    best_idx_next = idx_reg;
                    best_pid_next = cur_pid_reg;
                    best_w_next   = cur_w_reg;
                    best_e_next   = cur_e_reg;
                    sel_idx       = idx_reg;
                end
                if (CNT_W'(idx_reg) + CNT_W'(1) < count_reg)
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_LOAD;
                end
                else
                begin
                    scan_done = 1'b1;
                end
            end
            S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = shift_reg + IDX_W'(1);
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = shift_reg;
                wr_data    = rd_data_reg;
                shift_next = shift_reg + IDX_W'(1);
                if (CNT_W'(shift_reg) + CNT_W'(2) < count_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pid_next    = res_pid_reg;
                    out_est_next    = res_est_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (scan_done)
        begin
            res_status_next = ST_DISPATCHED;
            res_pid_next    = best_pid_next;
            res_est_next    = best_e_next;
            shift_next      = sel_idx;
            if (CNT_W'(sel_idx) + CNT_W'(1) < count_reg)
            begin
                state_next = S_SH_RD;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                state_next = S_POST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POLICY_FIFO;
            alpha_reg     <= ALPHA_RESET;
            tick_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            alpha_reg     <= alpha_next;
            tick_reg      <= tick_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        shift_reg      <= shift_next;
        best_idx_reg   <= best_idx_next;
        best_pid_reg   <= best_pid_next;
        best_w_reg     <= best_w_next;
        best_e_reg     <= best_e_next;
        cur_w_reg      <= cur_w_next;
        cur_e_reg      <= cur_e_next;
        cur_pid_reg    <= cur_pid_next;
        acc_reg        <= acc_next;
        p1_reg         <= p1_next;
        res_status_reg <= res_status_next;
        res_pid_reg    <= res_pid_next;
        res_est_reg    <= res_est_next;
        out_status_reg <= out_status_next;
        out_pid_reg    <= out_pid_next;
        out_est_reg    <= out_est_next;
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "fill count overflow")
    `ASSERT_IMPLIES(a_scan_in_range, state_reg == S_LOAD, CNT_W'(idx_reg) < count_reg, "scan past fill")
    `ASSERT_NEXT(a_enq_grows, enq_room, count_reg == $past(count_reg) + CNT_W'(1), "enqueue lost")
    `ASSERT_IMPLIES(a_result_from_post, $rose(out_valid_reg), $past(state_reg == S_POST), "result without post")

endmodule

### bench/testbench.sv
//==============================================================================
// HRRN ready-queue scheduler testbench
// Drives tick, enqueue, dispatch and unused commands through the command
// channel under several policy and alpha settings. A ready-table tracker
// predicts each result and checks every result transaction in order.
//==============================================================================
module testbench;
    import hrrn_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 58;
    localparam int NUM_PHASES  = 7;
    localparam int SETTLE_CYCLES = 150;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    chosen_pid;
        logic [DATA_W-1:0]   new_estimate;
    } outcome_t;

    class ready_table_tracker;
        logic [PID_W-1:0]   slot_pid      [QUEUE_DEPTH];
        logic [DATA_W-1:0]  slot_burst    [QUEUE_DEPTH];
        logic [DATA_W-1:0]  slot_estimate [QUEUE_DEPTH];
        logic [DATA_W-1:0]  slot_arrival  [QUEUE_DEPTH];
        int unsigned        occupancy;
        logic [DATA_W-1:0]  now_ticks;
        logic               policy;
        logic [ALPHA_W-1:0] alpha;
        outcome_t           due_outcomes[$];
        int unsigned        mismatches;
        int unsigned        commands_seen;
        int unsigned        results_seen;
        int unsigned        dispatches;
        int unsigned        full_hits;
        int unsigned        empty_hits;

        function new();
            occupancy     = 0;
            now_ticks     = '0;
            policy        = POLICY_FIFO;
            alpha         = ALPHA_RESET;
            mismatches    = 0;
            commands_seen = 0;
            results_seen  = 0;
            dispatches    = 0;
            full_hits     = 0;
            empty_hits    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_POLICY_MODE)
                policy = data[0];
            else if (idx == CFG_ALPHA_Q8)
                alpha = data[ALPHA_W-1:0];
        endfunction

        function logic [DATA_W-1:0] smoothed_estimate(logic [DATA_W-1:0] burst,
                                                      logic [DATA_W-1:0] est);
            logic [63:0]       weight;
            logic [63:0]       sum;
            logic [DATA_W-1:0] avg;
            weight = (alpha > ALPHA_ONE) ? {55'b0, ALPHA_ONE} : {55'b0, alpha};
            sum = weight * {32'b0, burst} + (64'd256 - weight) * {32'b0, est};
            avg = sum[39:8];
            return (avg == '0) ? 32'd1 : avg;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                   logic [DATA_W-1:0] burst, logic [DATA_W-1:0] est);
            outcome_t          o;
            int unsigned       pick;
            int unsigned       i;
            logic [DATA_W-1:0] wait32;
            logic [63:0]       best_wait;
            logic [63:0]       best_est;
            logic [63:0]       w;
            logic [63:0]       e;
            o = '0;
            o.status = ST_OK;
            commands_seen++;
            case (cmd)
                CMD_TICK: now_ticks = now_ticks + 32'd1;
                CMD_ENQUEUE:
                begin
                    if (occupancy >= QUEUE_DEPTH)
                    begin
                        o.status = ST_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        slot_pid[occupancy]      = pid;
                        slot_burst[occupancy]    = burst;
                        slot_estimate[occupancy] = est;
                        slot_arrival[occupancy]  = now_ticks;
                        occupancy++;
                    end
                end
                CMD_DISPATCH:
                begin
                    if (occupancy == 0)
                    begin
                        o.status = ST_EMPTY;
                        empty_hits++;
                    end
                    else
                    begin
                        pick = 0;
                        if (policy == POLICY_HRRN)
                        begin
                            wait32    = now_ticks - slot_arrival[0];
                            best_wait = {32'b0, wait32};
                            best_est  = {32'b0, smoothed_estimate(slot_burst[0],
                                                                  slot_estimate[0])};
                            for (i = 1; i < occupancy; i++)
                            begin
                                wait32 = now_ticks - slot_arrival[i];
                                w = {32'b0, wait32};
                                e = {32'b0, smoothed_estimate(slot_burst[i], slot_estimate[i])};
                                if (w * best_est > best_wait * e)
                                begin
                                    pick      = i;
                                    best_wait = w;
                                    best_est  = e;
                                end
                            end
                            o.new_estimate = best_est[DATA_W-1:0];
                        end
                        o.status     = ST_DISPATCHED;
                        o.chosen_pid = slot_pid[pick];
                        dispatches++;
                        for (i = pick; i + 1 < occupancy; i++)
                        begin
                            slot_pid[i]      = slot_pid[i+1];
                            slot_burst[i]    = slot_burst[i+1];
                            slot_estimate[i] = slot_estimate[i+1];
                            slot_arrival[i]  = slot_arrival[i+1];
                        end
                        occupancy--;
                    end
                end
                default: ;
            endcase
            due_outcomes.push_back(o);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 20)
                $display("MISMATCH: %0s", msg);
            mismatches++;
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [PID_W-1:0] pid,
                          logic [DATA_W-1:0] est);
            outcome_t want;
            results_seen++;
            if (due_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d pid=%0h est=%0h",
                                          status, pid, est));
            end
            else
            begin
                want = due_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_seen, status, want.status));
                if (pid !== want.chosen_pid)
                    report_mismatch($sformatf("result %0d chosen_pid %0h, want %0h",
                                              results_seen, pid, want.chosen_pid));
                if (est !== want.new_estimate)
                    report_mismatch($sformatf("result %0d new_estimate %0h, want %0h",
                                              results_seen, est, want.new_estimate));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic no_gaps;
    int   cycle_count;

    hrrn_cmd_if cmd_ch ();
    hrrn_res_if res_ch ();

    ready_table_tracker table_tracker;

    hrrn_ready_queue_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[hrrn_ready_queue_scheduler] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        res_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 31);

    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            table_tracker.write_register(cfg_index, cfg_data);
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            table_tracker.note_command(cmd_ch.command, cmd_ch.pid, cmd_ch.last_burst,
                                       cmd_ch.previous_estimate);
        if (rst_n && res_ch.valid && res_ch.ready)
            table_tracker.check_result(res_ch.status, res_ch.chosen_pid, res_ch.new_estimate);
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(0, 40);
            4: return $urandom_range(0, 100000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                                input logic [DATA_W-1:0] burst, input logic [DATA_W-1:0] est);
        cmd_ch.valid             <= 1'b1;
        cmd_ch.command           <= cmd;
        cmd_ch.pid               <= pid;
        cmd_ch.last_burst        <= burst;
        cmd_ch.previous_estimate <= est;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic maybe_pause();
        if (!no_gaps && $urandom_range(0, 99) < 31)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_for_outcomes();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (table_tracker.due_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic mode, input logic [ALPHA_W-1:0] alpha);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLICY_MODE;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, mode};
        @(posedge clk);
        cfg_index <= CFG_ALPHA_Q8;
        cfg_data  <= alpha;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_item();
        int unsigned       r;
        logic [CMD_W-1:0]  cmd;
        r = $urandom_range(0, 99);
        if (r < 28)
            cmd = CMD_TICK;
        else if (r < 63)
            cmd = CMD_ENQUEUE;
        else if (r < 95)
            cmd = CMD_DISPATCH;
        else
            cmd = CMD_UNUSED;
        maybe_pause();
        send_command(cmd, PID_W'($urandom_range(0, 16'hFFFF)), pick_value(), pick_value());
    endtask

    initial
    begin
        int i;
        int phase;
        logic               mode;
        logic [ALPHA_W-1:0] alpha;
        logic [DATA_W-1:0]  burst;
        logic [DATA_W-1:0]  est;
        logic [PID_W-1:0]   pid;

        table_tracker = new();
        no_gaps                  <= 1'b0;
        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_index                <= CFG_POLICY_MODE;
        cfg_data                 <= '0;
        cmd_ch.valid             <= 1'b0;
        cmd_ch.command           <= CMD_TICK;
        cmd_ch.pid               <= '0;
        cmd_ch.last_burst        <= '0;
        cmd_ch.previous_estimate <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: FIFO, alpha 128
        send_command(CMD_DISPATCH, 16'h1234, '1, '1);
        maybe_pause();
        send_command(CMD_UNUSED, 16'hFFFF, '1, '1);
        send_command(CMD_TICK, '0, '0, '0);
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            pid = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
            case (i % 4)
                0: burst = '0;
                1: burst = '1;
                2: burst = $urandom_range(1, 20);
                default: burst = $urandom;
            endcase
            case ((i / 4) % 4)
                0: est = '0;
                1: est = '1;
                2: est = $urandom_range(1, 20);
                default: est = $urandom;
            endcase
            maybe_pause();
            send_command(CMD_ENQUEUE, pid, burst, est);
        end
        send_command(CMD_ENQUEUE, 16'hABCD, '1, '0);
        send_command(CMD_DISPATCH, '0, '0, '0);
        wait_for_outcomes();

        // alpha beyond 256 saturates
        write_settings(POLICY_HRRN, 9'd511);
        send_command(CMD_TICK, '0, '0, '0);
        send_command(CMD_DISPATCH, '0, '0, '0);
        maybe_pause();
        send_command(CMD_DISPATCH, '0, '0, '0);
        wait_for_outcomes();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: begin mode = POLICY_HRRN; alpha = 9'd0;   end
                1: begin mode = POLICY_HRRN; alpha = 9'd256; end
                2: begin mode = POLICY_FIFO; alpha = 9'd128; end
                3: begin mode = POLICY_HRRN; alpha = 9'd1;   end
                4: begin mode = POLICY_HRRN; alpha = ALPHA_W'($urandom_range(0, 511)); end
                5: begin mode = POLICY_HRRN; alpha = 9'd255; end
                default: begin mode = POLICY_FIFO; alpha = 9'd511; end
            endcase
            write_settings(mode, alpha);
            no_gaps <= (phase == 3);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 0 && i == PHASE_ITEMS / 2)
                    wait_for_outcomes();
                send_random_item();
            end
            wait_for_outcomes();
            no_gaps <= 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (table_tracker.due_outcomes.size() != 0)
            table_tracker.report_mismatch($sformatf("%0d results never arrived",
                                                    table_tracker.due_outcomes.size()));
        $display("Run covered %0d commands and %0d result transactions over %0d settings:",
                 table_tracker.commands_seen, table_tracker.results_seen, NUM_PHASES + 2);
        $display("  %0d dispatches, %0d full-table rejects, %0d empty-table dispatches",
                 table_tracker.dispatches, table_tracker.full_hits, table_tracker.empty_hits);
        if (table_tracker.mismatches == 0)
            $display("[hrrn_ready_queue_scheduler] OK");
        else
            $display("[hrrn_ready_queue_scheduler] ERROR");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/hrrn_pkg.sv
rtl/core/hrrn_if.sv
rtl/core/hrrn_mul.sv
rtl/core/hrrn_ready_queue_scheduler.sv
bench/testbench.sv
